FILE: hdl/lpr_pkg.sv
package lpr_pkg;

  localparam int MaxLayers  = 8;
  localparam int MaxX       = 128;
  localparam int MaxY       = 128;
  localparam int CountWidth = 16;

  localparam int LayerW = $clog2(MaxLayers);
  localparam int XW     = $clog2(MaxX);
  localparam int YW     = $clog2(MaxY);
  localparam int AddrW  = LayerW + XW + YW;
  localparam int Depth  = MaxLayers * MaxX * MaxY;
  localparam int MemW   = 2 * CountWidth + 16;

  localparam logic [1:0] CMD_CAP   = 2'd0;
  localparam logic [1:0] CMD_ROUTE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAME  = 2'd1;
  localparam logic [1:0] ST_NOLAY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_DIR    = 3'd3;
  localparam logic [2:0] REG_COST   = 3'd4;
  localparam logic [2:0] REG_ALPHA  = 3'd5;

  // run phases: price 0..3, then update the two runs of the chosen shape
  localparam logic [2:0] RUN_HS = 3'd0;  // h at src y
  localparam logic [2:0] RUN_VT = 3'd1;  // v at dst x
  localparam logic [2:0] RUN_VS = 3'd2;  // v at src x
  localparam logic [2:0] RUN_HT = 3'd3;  // h at dst y
  localparam logic [2:0] RUN_U1 = 3'd4;
  localparam logic [2:0] RUN_U2 = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_DEC, S_QRD, S_QWAIT, S_QMUL, S_RUN, S_PICK, S_MULS, S_OUT
  } state_t;

  typedef struct packed {
    logic [CountWidth-1:0] dh;
    logic [CountWidth-1:0] dv;
    logic [15:0]           cap;
  } entry_t;

  function automatic logic [AddrW-1:0] mk_addr(logic [LayerW-1:0] l, logic [XW-1:0] x,
                                               logic [YW-1:0] y);
    return {l, x, y};
  endfunction

endpackage

FILE: hdl/lpr_ram.sv
module lpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/lshape_pattern_route_demand_top.sv
// clear walks the demand memory one entry a cycle
// one item at a time; a new request is taken only once the last result has been accepted
// reset: configuration registers return to their defaults and a clearing pass zeroes every
// demand entry, during which no request is accepted
module lshape_pattern_route_demand_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_layer,
  input  logic [6:0]  in_edge_x,
  input  logic [6:0]  in_edge_y,
  input  logic [15:0] in_cap_value,
  input  logic [6:0]  in_src_x,
  input  logic [6:0]  in_src_y,
  input  logic [6:0]  in_dst_x,
  input  logic [6:0]  in_dst_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_h_first,
  output logic [31:0] out_route_cost,
  output logic        out_h_hot,
  output logic [31:0] out_h_multiplier,
  output logic        out_v_hot,
  output logic [31:0] out_v_multiplier
);
  localparam int AW = lpr_pkg::AddrW;
  localparam int CW = lpr_pkg::CountWidth;

  logic [3:0]  nl_r;
  logic [7:0]  gw_r, gh_r, dir_r;
  logic [15:0] uc_r, al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_r <= 4'd8; gw_r <= 8'd128; gh_r <= 8'd128;
      dir_r <= 8'd0; uc_r <= 16'd256; al_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        lpr_pkg::REG_LAYERS: nl_r  <= cfg_data[3:0];
        lpr_pkg::REG_WIDTH:  gw_r  <= cfg_data[7:0];
        lpr_pkg::REG_HEIGHT: gh_r  <= cfg_data[7:0];
        lpr_pkg::REG_DIR:    dir_r <= cfg_data[7:0];
        lpr_pkg::REG_COST:   uc_r  <= cfg_data;
        lpr_pkg::REG_ALPHA:  al_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] nl;
  logic [7:0] gw, gh;
  assign nl = (nl_r > 4'(lpr_pkg::MaxLayers)) ? 4'(lpr_pkg::MaxLayers) : nl_r;
  assign gw = (gw_r > 8'(lpr_pkg::MaxX)) ? 8'(lpr_pkg::MaxX) : gw_r;
  assign gh = (gh_r > 8'(lpr_pkg::MaxY)) ? 8'(lpr_pkg::MaxY) : gh_r;

  // layer pick, narrow loop over layers one to seven
  logic [2:0] hl, vl;
  always_comb begin
    logic hf, vf;
    hf = 1'b0; vf = 1'b0; hl = 3'd1; vl = 3'd1;
    for (int l = 1; l < 8; l++) begin
      if (4'(l) < nl) begin
        if (!dir_r[l] && !hf) begin hl = 3'(l); hf = 1'b1; end
        if (dir_r[l] && !vf) begin vl = 3'(l); vf = 1'b1; end
      end
    end
  end

  // memory
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  lpr_pkg::entry_t      wdata, rdata;
  logic [lpr_pkg::MemW-1:0] rraw;
  assign rdata = lpr_pkg::entry_t'(rraw);

  lpr_ram #(.Width(lpr_pkg::MemW), .Depth(lpr_pkg::Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rraw)
  );

  lpr_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [2:0]  el_r, el_nxt;
  logic [6:0]  ex_r, ex_nxt, ey_r, ey_nxt;
  logic [15:0] cv_r, cv_nxt;
  logic [6:0]  sx_r, sx_nxt, sy_r, sy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [6:0]  i_r, i_nxt;          // next address to read
  logic        rv_r, rv_nxt;        // read issued last cycle
  logic [AW-1:0] ra_r, ra_nxt;      // address of that read
  logic [47:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic        hf_r, hf_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] rc_r, rc_nxt;
  logic        hh_r, hh_nxt, vh_r, vh_nxt;
  logic [31:0] hm_r, hm_nxt, vm_r, vm_nxt;
  logic [CW-1:0] ov_r, ov_nxt;
  logic        ovv_r, ovv_nxt;

  // run geometry
  logic [6:0] xlo, xhi, ylo, yhi, rlen, rfix;
  logic       run_h;
  logic [2:0] rphase;
  always_comb begin
    xlo = (sx_r < tx_r) ? sx_r : tx_r;  xhi = (sx_r < tx_r) ? tx_r : sx_r;
    ylo = (sy_r < ty_r) ? sy_r : ty_r;  yhi = (sy_r < ty_r) ? ty_r : sy_r;
    rphase = ph_r;
    if (ph_r == lpr_pkg::RUN_U1) rphase = hf_r ? lpr_pkg::RUN_HS : lpr_pkg::RUN_VS;
    if (ph_r == lpr_pkg::RUN_U2) rphase = hf_r ? lpr_pkg::RUN_VT : lpr_pkg::RUN_HT;
    run_h = (rphase == lpr_pkg::RUN_HS) || (rphase == lpr_pkg::RUN_HT);
    rlen  = run_h ? (xhi - xlo) : (yhi - ylo);
    case (rphase)
      lpr_pkg::RUN_HS: rfix = sy_r;
      lpr_pkg::RUN_VT: rfix = tx_r;
      lpr_pkg::RUN_VS: rfix = sx_r;
      default:         rfix = ty_r;
    endcase
  end

  logic [AW-1:0] run_addr;
  always_comb begin
    if (run_h) run_addr = lpr_pkg::mk_addr(hl, xlo + i_r, rfix);
    else       run_addr = lpr_pkg::mk_addr(vl, rfix, ylo + i_r);
  end

  logic [CW-1:0] dsel;
  logic [16:0]   exc;
  assign dsel = run_h ? rdata.dh : rdata.dv;
  assign exc  = ({1'b0, dsel} > {1'b0, rdata.cap}) ? 17'({1'b0, dsel} - {1'b0, rdata.cap})
                                                    : 17'd0;
  logic [47:0] ecost;
  assign ecost = 48'(uc_r) + (48'(exc) << 8);
  logic is_upd;
  assign is_upd = (ph_r == lpr_pkg::RUN_U1) || (ph_r == lpr_pkg::RUN_U2);
  logic [47:0] mprod;
  assign mprod = 48'(ov_r) * 48'(al_r);

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    cmd_nxt = cmd_r; el_nxt = el_r; ex_nxt = ex_r; ey_nxt = ey_r; cv_nxt = cv_r;
    sx_nxt = sx_r; sy_nxt = sy_r; tx_nxt = tx_r; ty_nxt = ty_r;
    ph_nxt = ph_r; i_nxt = i_r; rv_nxt = 1'b0; ra_nxt = ra_r;
    ca_nxt = ca_r; cb_nxt = cb_r; hf_nxt = hf_r; st_nxt = st_r; rc_nxt = rc_r;
    hh_nxt = hh_r; vh_nxt = vh_r; hm_nxt = hm_r; vm_nxt = vm_r;
    ov_nxt = ov_r; ovv_nxt = ovv_r;
    in_ready = 1'b0; we = 1'b0; waddr = clr_r; wdata = rdata;
    raddr = lpr_pkg::mk_addr(el_r, ex_r, ey_r);
    case (state_r)
      lpr_pkg::S_CLR: begin
        // keep capacity, zero both demand counts
        raddr = clr_r;
        if (rv_r) begin
          we = 1'b1; waddr = ra_r; wdata = '0; wdata.cap = rdata.cap;
        end
        if (rv_r && ra_r == AW'(lpr_pkg::Depth - 1)) begin
          state_nxt = (cmd_r == lpr_pkg::CMD_CLEAR) ? lpr_pkg::S_OUT : lpr_pkg::S_IDLE;
        end else begin
          rv_nxt = 1'b1; ra_nxt = clr_r; clr_nxt = clr_r + 1'b1;
        end
      end
      lpr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_cmd; el_nxt = in_layer; ex_nxt = in_edge_x; ey_nxt = in_edge_y;
          cv_nxt = in_cap_value; sx_nxt = in_src_x; sy_nxt = in_src_y;
          tx_nxt = in_dst_x; ty_nxt = in_dst_y;
          st_nxt = lpr_pkg::ST_OK; hf_nxt = 1'b0; rc_nxt = '0;
          hh_nxt = 1'b0; vh_nxt = 1'b0; hm_nxt = '0; vm_nxt = '0;
          state_nxt = lpr_pkg::S_DEC;
        end
      end
      lpr_pkg::S_DEC: begin
        case (cmd_r)
          lpr_pkg::CMD_CLEAR: begin clr_nxt = '0; state_nxt = lpr_pkg::S_CLR; end
          lpr_pkg::CMD_ROUTE: begin
            if (nl < 4'd2) begin st_nxt = lpr_pkg::ST_NOLAY; state_nxt = lpr_pkg::S_OUT; end
            else if ({1'b0, sx_r} >= gw || {1'b0, tx_r} >= gw ||
                     {1'b0, sy_r} >= gh || {1'b0, ty_r} >= gh) begin
              st_nxt = lpr_pkg::ST_RANGE; state_nxt = lpr_pkg::S_OUT;
            end else if (sx_r == tx_r && sy_r == ty_r) begin
              st_nxt = lpr_pkg::ST_SAME; state_nxt = lpr_pkg::S_OUT;
            end else begin
              ph_nxt = lpr_pkg::RUN_HS; i_nxt = '0;
              ca_nxt = '0; cb_nxt = '0; state_nxt = lpr_pkg::S_RUN;
            end
          end
          default: begin
            if ({1'b0, el_r} >= nl || {1'b0, ex_r} >= gw || {1'b0, ey_r} >= gh) begin
              st_nxt = lpr_pkg::ST_RANGE; state_nxt = lpr_pkg::S_OUT;
            end else state_nxt = lpr_pkg::S_QRD;
          end
        endcase
      end
      lpr_pkg::S_QRD: state_nxt = lpr_pkg::S_QWAIT;
      lpr_pkg::S_QWAIT: begin
        if (cmd_r == lpr_pkg::CMD_CAP) begin
          we = 1'b1; waddr = lpr_pkg::mk_addr(el_r, ex_r, ey_r);
          wdata = rdata; wdata.cap = cv_r; state_nxt = lpr_pkg::S_OUT;
        end else begin
          ovv_nxt = 1'b0; ov_nxt = '0;
          if (el_r != 3'd0) begin
            if (!dir_r[el_r] && ({1'b0, ex_r} + 8'd1 < gw) && rdata.dh > rdata.cap) begin
              hh_nxt = 1'b1; ov_nxt = rdata.dh - rdata.cap; ovv_nxt = 1'b0;
            end
            if (dir_r[el_r] && ({1'b0, ey_r} + 8'd1 < gh) && rdata.dv > rdata.cap) begin
              vh_nxt = 1'b1; ov_nxt = rdata.dv - rdata.cap; ovv_nxt = 1'b1;
            end
          end
          state_nxt = lpr_pkg::S_QMUL;
        end
      end
      lpr_pkg::S_QMUL: begin
        if (hh_r) hm_nxt = (mprod > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : mprod[31:0];
        if (vh_r && ovv_r) vm_nxt = (mprod > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : mprod[31:0];
        state_nxt = lpr_pkg::S_OUT;
      end
      lpr_pkg::S_RUN: begin
        // a new read waits until the last read's data is used, which keeps update writes free of same-entry overlap
        raddr = run_addr;
        if (rv_r) begin
          if (is_upd) begin
            we = 1'b1; waddr = ra_r; wdata = rdata;
            if (run_h) begin
              if (rdata.dh != {CW{1'b1}}) wdata.dh = rdata.dh + 1'b1;
            end else if (rdata.dv != {CW{1'b1}}) wdata.dv = rdata.dv + 1'b1;
          end else if (ph_r == lpr_pkg::RUN_HS || ph_r == lpr_pkg::RUN_VT) begin
            ca_nxt = ca_r + ecost;
          end else begin
            cb_nxt = cb_r + ecost;
          end
        end else if (i_r < rlen) begin
          rv_nxt = 1'b1; ra_nxt = run_addr; i_nxt = i_r + 1'b1;
        end else begin
          i_nxt = '0;
          case (ph_r)
            lpr_pkg::RUN_HT: state_nxt = lpr_pkg::S_PICK;
            lpr_pkg::RUN_U2: state_nxt = lpr_pkg::S_OUT;
            default: ph_nxt = ph_r + 3'd1;
          endcase
        end
      end
      lpr_pkg::S_PICK: begin
        hf_nxt = (ca_r <= cb_r);
        state_nxt = lpr_pkg::S_MULS;
      end
      lpr_pkg::S_MULS: begin
        if (hf_r) rc_nxt = (ca_r > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : ca_r[31:0];
        else      rc_nxt = (cb_r > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : cb_r[31:0];
        ph_nxt = lpr_pkg::RUN_U1; i_nxt = '0; state_nxt = lpr_pkg::S_RUN;
      end
      lpr_pkg::S_OUT: begin
        if (out_ready) state_nxt = lpr_pkg::S_IDLE;
      end
      default: state_nxt = lpr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::S_CLR; clr_r <= '0; rv_r <= 1'b0; cmd_r <= lpr_pkg::CMD_CAP;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; rv_r <= rv_nxt; cmd_r <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    el_r <= el_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt; cv_r <= cv_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
    ph_r <= ph_nxt; i_r <= i_nxt; ra_r <= ra_nxt;
    ca_r <= ca_nxt; cb_r <= cb_nxt; hf_r <= hf_nxt; st_r <= st_nxt; rc_r <= rc_nxt;
    hh_r <= hh_nxt; vh_r <= vh_nxt; hm_r <= hm_nxt; vm_r <= vm_nxt;
    ov_r <= ov_nxt; ovv_r <= ovv_nxt;
  end

  assign out_valid        = (state_r == lpr_pkg::S_OUT);
  assign out_status       = st_r;
  assign out_h_first      = hf_r;
  assign out_route_cost   = rc_r;
  assign out_h_hot        = hh_r;
  assign out_h_multiplier = hm_r;
  assign out_v_hot        = vh_r;
  assign out_v_multiplier = vm_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_hot_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_h_hot && out_v_hot)) else $error("both hot flags set");
  a_mult_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_h_hot) |-> (out_h_multiplier == 32'd0))
    else $error("multiplier without hot flag");
  a_write_run: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r == lpr_pkg::S_RUN) |-> $past(rv_nxt))
    else $error("demand write without prior read");
endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  layer;
    logic [6:0]  ex;
    logic [6:0]  ey;
    logic [15:0] cap;
    logic [6:0]  sx;
    logic [6:0]  sy;
    logic [6:0]  tx;
    logic [6:0]  ty;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        h_first;
    logic [31:0] route_cost;
    logic        h_hot;
    logic [31:0] h_mult;
    logic        v_hot;
    logic [31:0] v_mult;
  } answer_t;

  localparam int NumEntries = lpr_pkg::MaxLayers * lpr_pkg::MaxX * lpr_pkg::MaxY;
  localparam logic [63:0] Sat32 = 64'hFFFF_FFFF;
  localparam logic [15:0] DemMax = 16'hFFFF;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = lpr_pkg::REG_LAYERS;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_cmd = lpr_pkg::CMD_CAP;
  logic [2:0] in_layer = '0;
  logic [6:0] in_edge_x = '0, in_edge_y = '0;
  logic [15:0] in_cap_value = '0;
  logic [6:0] in_src_x = '0, in_src_y = '0, in_dst_x = '0, in_dst_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic out_h_first, out_h_hot, out_v_hot;
  logic [31:0] out_route_cost, out_h_multiplier, out_v_multiplier;

  lshape_pattern_route_demand_top dut (.*);

  always #10 clk = ~clk;

  // shadow of the block
  logic [15:0] cap_mem [NumEntries];
  logic [15:0] dem_h [NumEntries];
  logic [15:0] dem_v [NumEntries];
  bit cap_known [NumEntries];
  logic [3:0] r_layers;
  logic [7:0] r_width, r_height, r_dir;
  logic [15:0] r_cost, r_alpha;

  answer_t expected_q [$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  longint cyc = 0;
  longint hold_end = 0;

  function automatic int eff_nl();
    return (r_layers > lpr_pkg::MaxLayers) ? lpr_pkg::MaxLayers : r_layers;
  endfunction
  function automatic int eff_w();
    return (r_width > lpr_pkg::MaxX) ? lpr_pkg::MaxX : r_width;
  endfunction
  function automatic int eff_h();
    return (r_height > lpr_pkg::MaxY) ? lpr_pkg::MaxY : r_height;
  endfunction
  function automatic int idx(int l, int x, int y);
    return (l * lpr_pkg::MaxX + x) * lpr_pkg::MaxY + y;
  endfunction
  function automatic bit vert(int l);
    return r_dir[l[2:0]];
  endfunction
  function automatic int layer_for(bit want_v);
    for (int l = 1; l < eff_nl(); l++)
      if (vert(l) == want_v) return l;
    return 1;
  endfunction
  function automatic logic [63:0] edge_price(logic [15:0] d, logic [15:0] c);
    logic [63:0] over;
    over = (d > c) ? 64'(d - c) : 64'd0;
    return 64'(r_cost) + (over << 8);
  endfunction
  function automatic logic [63:0] price_h(int l, int lo, int hi, int y);
    logic [63:0] s = 0;
    for (int x = lo; x < hi; x++) s += edge_price(dem_h[idx(l, x, y)], cap_mem[idx(l, x, y)]);
    return s;
  endfunction
  function automatic logic [63:0] price_v(int l, int x, int lo, int hi);
    logic [63:0] s = 0;
    for (int y = lo; y < hi; y++) s += edge_price(dem_v[idx(l, x, y)], cap_mem[idx(l, x, y)]);
    return s;
  endfunction
  function automatic void load_h(int l, int lo, int hi, int y);
    for (int x = lo; x < hi; x++)
      if (dem_h[idx(l, x, y)] != DemMax) dem_h[idx(l, x, y)]++;
  endfunction
  function automatic void load_v(int l, int x, int lo, int hi);
    for (int y = lo; y < hi; y++)
      if (dem_v[idx(l, x, y)] != DemMax) dem_v[idx(l, x, y)]++;
  endfunction

  function automatic answer_t route_outcome(request_t r);
    answer_t a;
    int hl, vl, xlo, xhi, ylo, yhi;
    logic [63:0] c_hv, c_vh, c;
    a = '0;
    if (eff_nl() < 2) begin
      a.status = lpr_pkg::ST_NOLAY;
    end else if (r.sx >= eff_w() || r.tx >= eff_w() || r.sy >= eff_h() || r.ty >= eff_h()) begin
      a.status = lpr_pkg::ST_RANGE;
    end else if (r.sx == r.tx && r.sy == r.ty) begin
      a.status = lpr_pkg::ST_SAME;
    end else begin
      hl = layer_for(0);
      vl = layer_for(1);
      xlo = (r.sx < r.tx) ? r.sx : r.tx;
      xhi = (r.sx < r.tx) ? r.tx : r.sx;
      ylo = (r.sy < r.ty) ? r.sy : r.ty;
      yhi = (r.sy < r.ty) ? r.ty : r.sy;
      c_hv = price_h(hl, xlo, xhi, r.sy) + price_v(vl, r.tx, ylo, yhi);
      c_vh = price_v(vl, r.sx, ylo, yhi) + price_h(hl, xlo, xhi, r.ty);
      if (c_hv <= c_vh) begin
        load_h(hl, xlo, xhi, r.sy);
        load_v(vl, r.tx, ylo, yhi);
        a.h_first = 1'b1;
        c = c_hv;
      end else begin
        load_v(vl, r.sx, ylo, yhi);
        load_h(hl, xlo, xhi, r.ty);
        c = c_vh;
      end
      a.route_cost = (c > Sat32) ? 32'hFFFF_FFFF : c[31:0];
    end
    return a;
  endfunction

  function automatic answer_t demand_outcome(request_t r);
    answer_t a;
    int k;
    logic [15:0] c;
    a = '0;
    case (r.cmd)
      lpr_pkg::CMD_CLEAR: begin
        for (int i = 0; i < NumEntries; i++) begin
          dem_h[i] = '0;
          dem_v[i] = '0;
        end
      end
      lpr_pkg::CMD_ROUTE: a = route_outcome(r);
      default: begin
        if (r.layer >= eff_nl() || r.ex >= eff_w() || r.ey >= eff_h()) begin
          a.status = lpr_pkg::ST_RANGE;
        end else begin
          k = idx(r.layer, r.ex, r.ey);
          if (r.cmd == lpr_pkg::CMD_CAP) begin
            cap_mem[k] = r.cap;
            cap_known[k] = 1;
          end else if (r.layer >= 1) begin
            c = cap_mem[k];
            if (!vert(r.layer) && r.ex + 1 < eff_w() && dem_h[k] > c) begin
              a.h_hot = 1;
              a.h_mult = 32'((dem_h[k] - c) * 32'(r_alpha));
            end
            if (vert(r.layer) && r.ey + 1 < eff_h() && dem_v[k] > c) begin
              a.v_hot = 1;
              a.v_mult = 32'((dem_v[k] - c) * 32'(r_alpha));
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  // receiver side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc < hold_end) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_h_first, out_route_cost, out_h_hot, out_h_multiplier,
              out_v_hot, out_v_multiplier};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic send(request_t r);
    in_valid <= 1'b1;
    {in_cmd, in_layer, in_edge_x, in_edge_y, in_cap_value,
     in_src_x, in_src_y, in_dst_x, in_dst_y} <= r;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(demand_outcome(r));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] i, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (i)
      lpr_pkg::REG_LAYERS: r_layers = v[3:0];
      lpr_pkg::REG_WIDTH:  r_width = v[7:0];
      lpr_pkg::REG_HEIGHT: r_height = v[7:0];
      lpr_pkg::REG_DIR:    r_dir = v[7:0];
      lpr_pkg::REG_COST:   r_cost = v;
      lpr_pkg::REG_ALPHA:  r_alpha = v;
      default: ;
    endcase
  endtask

  task automatic set_all(int nl, int w, int h, int dir, int c, int al);
    write_reg(lpr_pkg::REG_LAYERS, 16'(nl));
    write_reg(lpr_pkg::REG_WIDTH, 16'(w));
    write_reg(lpr_pkg::REG_HEIGHT, 16'(h));
    write_reg(lpr_pkg::REG_DIR, 16'(dir));
    write_reg(lpr_pkg::REG_COST, 16'(c));
    write_reg(lpr_pkg::REG_ALPHA, 16'(al));
  endtask

  function automatic request_t noise();
    request_t r;
    r = $bits(request_t)'({$urandom, $urandom, $urandom});
    return r;
  endfunction

  // capacity must be known before any request reads it
  task automatic ensure_cap(int l, int x, int y);
    request_t r;
    if (!cap_known[idx(l, x, y)]) begin
      r = noise();
      r.cmd = lpr_pkg::CMD_CAP;
      r.layer = 3'(l);
      r.ex = 7'(x);
      r.ey = 7'(y);
      if ($urandom_range(3) != 0) r.cap = 16'($urandom_range(3));
      send(r);
    end
  endtask

  task automatic route(int sx, int sy, int tx, int ty);
    request_t r;
    int hl, vl, xlo, xhi, ylo, yhi;
    r = noise();
    r.cmd = lpr_pkg::CMD_ROUTE;
    r.sx = 7'(sx);
    r.sy = 7'(sy);
    r.tx = 7'(tx);
    r.ty = 7'(ty);
    if (eff_nl() >= 2 && sx < eff_w() && tx < eff_w() && sy < eff_h() && ty < eff_h()) begin
      hl = layer_for(0);
      vl = layer_for(1);
      xlo = (sx < tx) ? sx : tx;
      xhi = (sx < tx) ? tx : sx;
      ylo = (sy < ty) ? sy : ty;
      yhi = (sy < ty) ? ty : sy;
      for (int x = xlo; x < xhi; x++) begin
        ensure_cap(hl, x, sy);
        ensure_cap(hl, x, ty);
      end
      for (int y = ylo; y < yhi; y++) begin
        ensure_cap(vl, sx, y);
        ensure_cap(vl, tx, y);
      end
    end
    send(r);
  endtask

  task automatic query(int l, int x, int y);
    request_t r;
    r = noise();
    r.cmd = lpr_pkg::CMD_QUERY;
    r.layer = 3'(l);
    r.ex = 7'(x);
    r.ey = 7'(y);
    if (l >= 1 && l < eff_nl() && x < eff_w() && y < eff_h()) ensure_cap(l, x, y);
    send(r);
  endtask

  task automatic cap_write(int l, int x, int y, int v);
    request_t r;
    r = noise();
    r.cmd = lpr_pkg::CMD_CAP;
    r.layer = 3'(l);
    r.ex = 7'(x);
    r.ey = 7'(y);
    r.cap = 16'(v);
    send(r);
  endtask

  task automatic clear_demand();
    request_t r;
    r = noise();
    r.cmd = lpr_pkg::CMD_CLEAR;
    send(r);
  endtask

  task automatic test_directed();
    cap_write(7, 127, 127, 16'hFFFF);
    cap_write(1, 0, 0, 0);
    route(0, 0, 127, 127);
    route(127, 127, 0, 0);
    route(5, 5, 5, 5);
    route(3, 0, 3, 9);
    route(0, 4, 9, 4);
    for (int i = 0; i < 4; i++) route(0, 0, 1, 0);
    query(1, 0, 0);
    query(0, 0, 0);
    query(7, 127, 127);
    drain();
    set_all(8, 4, 4, 8'b1010_1010, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) route(0, 0, 3, 3);
    query(1, 0, 0);
    query(2, 0, 0);
    query(1, 3, 0);
    query(2, 0, 3);
    query(3, 4, 0);
    cap_write(2, 0, 9, 5);
    route(0, 0, 5, 1);
    clear_demand();
    query(1, 0, 0);
    drain();
    set_all(1, 4, 4, 0, 256, 256);
    route(0, 0, 1, 1);
    route(9, 9, 1, 1);
    drain();
  endtask

  task automatic random_items(int n);
    int w, h, nl, k, sx, sy, start;
    request_t r;
    start = items_sent;
    while (items_sent < start + n) begin
      w = eff_w();
      h = eff_h();
      nl = eff_nl();
      k = $urandom_range(99);
      if (k < 10 || w == 0 || h == 0) begin
        r = noise();
        case (r.cmd)
          lpr_pkg::CMD_ROUTE: route(r.sx, r.sy, r.tx, r.ty);
          lpr_pkg::CMD_QUERY: query(r.layer, r.ex, r.ey);
          default: send(r);
        endcase
      end else if (k < 20) begin
        cap_write($urandom_range(nl > 0 ? nl - 1 : 0), $urandom_range(w - 1),
                  $urandom_range(h - 1), $urandom_range(3) == 0 ? $urandom : $urandom_range(4));
      end else if (k < 65) begin
        sx = $urandom_range(w - 1);
        sy = $urandom_range(h - 1);
        route(sx, sy, $urandom_range(sx > 6 ? sx - 6 : 0, sx + 6 < w ? sx + 6 : w - 1),
              $urandom_range(sy > 6 ? sy - 6 : 0, sy + 6 < h ? sy + 6 : h - 1));
      end else begin
        query($urandom_range(nl > 0 ? nl - 1 : 0), $urandom_range(w - 1), $urandom_range(h - 1));
      end
    end
  endtask

  task automatic test_random();
    int idle_modes [4] = '{63, 0, 63, 29};
    int stall_modes [4] = '{0, 63, 63, 29};
    for (int p = 0; p < 8; p++) begin
      idle_pct = (p == 0) ? 0 : idle_modes[p % 4];
      stall_pct = (p == 0) ? 0 : stall_modes[p % 4];
      case (p)
        0: set_all(15, 255, 255, 8'hFF, 0, 0);
        1: set_all(2, 2, 2, 8'h00, 16'hFFFF, 16'hFFFF);
        2: set_all(0, 8, 8, 8'h55, 256, 256);
        3: set_all(8, 128, 128, 8'hAA, 1, 300);
        default: set_all($urandom_range(2, 8), $urandom_range(2, 12), $urandom_range(2, 12),
                         $urandom_range(255), $urandom_range(1024), $urandom_range(65535));
      endcase
      random_items(25);
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_pressure();
    set_all(4, 6, 6, 8'h04, 128, 512);
    hold_end = cyc + 400;
    random_items(12);
    drain();
    route(0, 0, 5, 5);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NumEntries; i++) begin
      cap_mem[i] = '0;
      dem_h[i] = '0;
      dem_v[i] = '0;
      cap_known[i] = 0;
    end
    r_layers = 8;
    r_width = 128;
    r_height = 128;
    r_dir = 0;
    r_cost = 256;
    r_alpha = 256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_pressure();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hdl/lpr_pkg.sv
hdl/lpr_ram.sv
hdl/lshape_pattern_route_demand_top.sv
test/tb.sv
